FILE: rtl/core/arlb_pkg.sv
// Shared types and register codes for the audio-reactive level bus.
package arlb_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DESKTOP_GAIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MICROPHONE_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BEAT_GAIN       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_FACTOR    = 3'd4;

    // Sequencer states, one per step of a tick
    typedef enum logic [3:0] {
        S_IDLE,
        S_DIN,
        S_MIN,
        S_ENVD,
        S_ENVM,
        S_BASE,
        S_BDEC,
        S_PDEC,
        S_TRANS,
        S_TMUL,
        S_TWAIT,
        S_QCLAMP,
        S_RECIP,
        S_RWAIT,
        S_CAND,
        S_OUT
    } t_state;

    // Rounding and scaling mode of the shared multiplier
    typedef enum logic [1:0] {
        MOP_QMUL,   // round half up, drop the fraction
        MOP_BEAT,   // round for the divide by five that follows
        MOP_RECIP   // reciprocal multiply, truncate
    } t_mop;

    typedef struct packed {
        logic issue;
        t_mop mode;
    } t_mul_ctl;

endpackage

FILE: rtl/core/arlb_cfg.sv
// Configuration register bank of the audio-reactive level bus.
module arlb_cfg
    import arlb_pkg::*;
#(
    parameter int FRAC_BITS = 14
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [FRAC_BITS+2:0]   i_cfg_data,
    output logic                   o_cfg_ready,
    output logic                   o_enabled,
    output logic [FRAC_BITS+1:0]   o_desktop_gain,
    output logic [FRAC_BITS+1:0]   o_microphone_gain,
    output logic [FRAC_BITS+6:0]   o_beat_gain13,
    output logic [FRAC_BITS-1:0]   o_decay_factor
);

    localparam int GW  = FRAC_BITS + 2;
    localparam int BGW = FRAC_BITS + 3;
    localparam int OPW = FRAC_BITS + 7;

    localparam longint unsigned ONE_L   = 64'd1 << FRAC_BITS;
    localparam longint unsigned MG_RST  = (ONE_L * 6 + 2) / 5;
    localparam longint unsigned BG_RST  = (ONE_L * 9 + 2) / 5;
    localparam longint unsigned DEC_RST = (ONE_L * 82 + 50) / 100;

    logic                 r_enabled;
    logic [GW-1:0]        r_desktop_gain;
    logic [GW-1:0]        r_microphone_gain;
    logic [OPW-1:0]       r_beat_gain13;
    logic [FRAC_BITS-1:0] r_decay_factor;

    logic [OPW-1:0]       n_bg_ext;
    logic [OPW-1:0]       n_beat_gain13;

    // Keep the beat gain premultiplied by thirteen
    always_comb begin
        n_bg_ext      = OPW'(i_cfg_data[BGW-1:0]);
        n_beat_gain13 = (n_bg_ext << 3) + (n_bg_ext << 2) + n_bg_ext;
    end

    // Take register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled         <= 1'b1;
            r_desktop_gain    <= GW'(ONE_L);
            r_microphone_gain <= GW'(MG_RST);
            r_beat_gain13     <= OPW'(BG_RST * 13);
            r_decay_factor    <= FRAC_BITS'(DEC_RST);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ENABLED:         r_enabled         <= i_cfg_data[0];
                CFG_DESKTOP_GAIN:    r_desktop_gain    <= i_cfg_data[GW-1:0];
                CFG_MICROPHONE_GAIN: r_microphone_gain <= i_cfg_data[GW-1:0];
                CFG_BEAT_GAIN:       r_beat_gain13     <= n_beat_gain13;
                CFG_DECAY_FACTOR:    r_decay_factor    <= i_cfg_data[FRAC_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready       = 1'b1;
    assign o_enabled         = r_enabled;
    assign o_desktop_gain    = r_desktop_gain;
    assign o_microphone_gain = r_microphone_gain;
    assign o_beat_gain13     = r_beat_gain13;
    assign o_decay_factor    = r_decay_factor;

endmodule

FILE: rtl/core/arlb_mul.sv
// Shared two-stage multiplier with rounding and scaling for the level bus.
module arlb_mul
    import arlb_pkg::*;
#(
    parameter int FRAC_BITS = 14
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_mul_ctl             i_ctl,
    input  logic [FRAC_BITS+6:0] i_a,
    input  logic [FRAC_BITS+6:0] i_b,
    output logic [FRAC_BITS+7:0] o_res
);

    localparam int OPW = FRAC_BITS + 7;
    localparam int PW  = 2 * OPW;
    localparam int RW  = FRAC_BITS + 8;
    localparam int RSH = FRAC_BITS + 9;

    localparam logic [PW:0] RND_Q = (PW + 1)'(1) << (FRAC_BITS - 1);
    localparam logic [PW:0] RND_B = (PW + 1)'(5) << (FRAC_BITS - 1);

    logic [PW-1:0] r_prod;
    t_mop          r_mode;
    logic          r_busy;
    logic [RW-1:0] r_res;

    logic [PW:0]   n_sum;
    logic [RW-1:0] n_res;

    // Stage one: raw product
    always_ff @(posedge i_clk) begin
        if (i_ctl.issue) begin
            r_prod <= PW'(i_a) * PW'(i_b);
            r_mode <= i_ctl.mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= i_ctl.issue;
        end
    end

    // Stage two: add the rounding term and drop the fraction, or truncate for the reciprocal
    always_comb begin
        n_sum = {1'b0, r_prod};
        n_res = '0;
        unique case (r_mode)
            MOP_QMUL: begin
                n_sum = {1'b0, r_prod} + RND_Q;
                n_res = n_sum[FRAC_BITS +: RW];
            end
            MOP_BEAT: begin
                n_sum = {1'b0, r_prod} + RND_B;
                n_res = n_sum[FRAC_BITS +: RW];
            end
            MOP_RECIP: begin
                n_res = RW'(n_sum[PW:RSH]);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

FILE: rtl/core/audio_reactive_level_bus_core.sv
// Top level of the audio-reactive level bus: tick sequencer and level datapath.
//
//  channel  handshake                   payload
//  input    i_in_valid / o_in_stall     i_desktop_raw, i_microphone_raw, i_pulse_strength
//  output   o_out_valid / i_out_stall   five levels, o_master_level to o_pulse_level
//  config   i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// A tick runs through the sequencer states in order, from its transfer to its result
// entering the output register; no new tick is taken until the last one is through,
// as nine products share one two-stage multiplier.
// Reset (synchronous, active low) clears the level state and restores default gains.
// A waiting result does not block the next tick; a tick whose result is ready
// holds until the output register is free.
module audio_reactive_level_bus_core
    import arlb_pkg::*;
#(
    parameter int FRAC_BITS = 14
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [FRAC_BITS:0]   i_desktop_raw,
    input  logic [FRAC_BITS:0]   i_microphone_raw,
    input  logic [FRAC_BITS:0]   i_pulse_strength,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [FRAC_BITS:0]   o_master_level,
    output logic [FRAC_BITS:0]   o_desktop_level,
    output logic [FRAC_BITS:0]   o_microphone_level,
    output logic [FRAC_BITS:0]   o_beat_out,
    output logic [FRAC_BITS:0]   o_pulse_level,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [FRAC_BITS+2:0] i_cfg_data
);

    localparam int LW  = FRAC_BITS + 1;
    localparam int GW  = FRAC_BITS + 2;
    localparam int BW  = FRAC_BITS + 4;
    localparam int OPW = FRAC_BITS + 7;
    localparam int RW  = FRAC_BITS + 8;

    localparam longint unsigned PMIN_L  = ((64'd5 << FRAC_BITS) + 64'd50) / 64'd100;
    localparam longint unsigned KBASE_L = ((64'd55 << FRAC_BITS) + 64'd500) / 64'd1000;
    localparam longint unsigned KBD_L   = ((64'd68 << FRAC_BITS) + 64'd50) / 64'd100;
    localparam longint unsigned RECIP_L = ((64'd1 << (FRAC_BITS + 9)) + 64'd4) / 64'd5;

    localparam logic [LW-1:0]        LVL_MAX   = LW'(3) << (FRAC_BITS - 1);
    localparam logic [LW-1:0]        PULSE_MIN = LW'(PMIN_L);
    localparam logic [FRAC_BITS-1:0] K_BASE    = FRAC_BITS'(KBASE_L);
    localparam logic [FRAC_BITS-1:0] K_BDECAY  = FRAC_BITS'(KBD_L);
    localparam logic [OPW-1:0]       K_RECIP   = OPW'(RECIP_L);
    localparam logic [BW-1:0]        BEAT_SAT  = '1;
    localparam logic [RW-1:0]        Q_CLAMP   = RW'(5) << (FRAC_BITS + 4);

    // Configuration
    logic                 cfg_enabled;
    logic [GW-1:0]        cfg_desktop_gain;
    logic [GW-1:0]        cfg_microphone_gain;
    logic [OPW-1:0]       cfg_beat_gain13;
    logic [FRAC_BITS-1:0] cfg_decay;

    // Sequencer and multiplier interface
    t_state         r_state;
    t_state         n_state;
    t_mul_ctl       mul_ctl;
    logic [OPW-1:0] mul_a;
    logic [OPW-1:0] mul_b;
    logic [RW-1:0]  mul_res;

    // Level state
    logic [LW-1:0] r_env_d;
    logic [LW-1:0] r_env_m;
    logic [LW-1:0] r_base;
    logic [BW-1:0] r_beat;
    logic [LW-1:0] r_pulse;
    logic          r_out_valid;

    // Per-tick working registers
    logic [LW-1:0]  r_raw_d;
    logic [LW-1:0]  r_raw_m;
    logic [LW-1:0]  r_din;
    logic [LW-1:0]  r_min;
    logic [LW-1:0]  r_diff;
    logic           r_up;
    logic [LW-1:0]  r_trans;
    logic [OPW-1:0] r_qc;
    logic [LW-1:0]  r_out_master;
    logic [LW-1:0]  r_out_dl;
    logic [LW-1:0]  r_out_ml;
    logic [LW-1:0]  r_out_beat;
    logic [LW-1:0]  r_out_pl;

    // Combinational helpers
    logic          slot_free;
    logic [LW-1:0] n_psc;
    logic [LW-1:0] n_scaled;
    logic [LW-1:0] n_res_lvl;
    logic [RW-1:0] n_cand;
    logic [BW-1:0] n_beat_fin;
    logic [LW-1:0] n_dl;
    logic [LW-1:0] n_ml;
    logic [LW-1:0] n_beat_o;
    logic [LW-1:0] n_master;

    arlb_cfg #(
        .FRAC_BITS (FRAC_BITS)
    ) u_cfg (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_cfg_ready       (o_cfg_ready),
        .o_enabled         (cfg_enabled),
        .o_desktop_gain    (cfg_desktop_gain),
        .o_microphone_gain (cfg_microphone_gain),
        .o_beat_gain13     (cfg_beat_gain13),
        .o_decay_factor    (cfg_decay)
    );

    arlb_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mul_ctl),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_res   (mul_res)
    );

    assign slot_free = !r_out_valid || !i_out_stall;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_DIN;
            S_DIN:    n_state = S_MIN;
            S_MIN:    n_state = S_ENVD;
            S_ENVD:   n_state = S_ENVM;
            S_ENVM:   n_state = S_BASE;
            S_BASE:   n_state = S_BDEC;
            S_BDEC:   n_state = S_PDEC;
            S_PDEC:   n_state = S_TRANS;
            S_TRANS:  n_state = S_TMUL;
            S_TMUL:   n_state = S_TWAIT;
            S_TWAIT:  n_state = S_QCLAMP;
            S_QCLAMP: n_state = S_RECIP;
            S_RECIP:  n_state = S_RWAIT;
            S_RWAIT:  n_state = S_CAND;
            S_CAND:   n_state = S_OUT;
            S_OUT:    if (slot_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer outputs: input stall and multiplier issue
    always_comb begin
        o_in_stall    = 1'b1;
        mul_ctl.issue = 1'b0;
        mul_ctl.mode  = MOP_QMUL;
        mul_a         = '0;
        mul_b         = '0;
        unique case (r_state)
            S_IDLE: o_in_stall = 1'b0;
            S_DIN: begin
                mul_ctl.issue = 1'b1;
                mul_a         = OPW'(r_raw_d);
                mul_b         = OPW'(cfg_desktop_gain);
            end
            S_MIN: begin
                mul_ctl.issue = 1'b1;
                mul_a         = OPW'(r_raw_m);
                mul_b         = OPW'(cfg_microphone_gain);
            end
            S_ENVD: begin
                mul_ctl.issue = 1'b1;
                mul_a         = OPW'(r_env_d);
                mul_b         = OPW'(cfg_decay);
            end
            S_ENVM: begin
                mul_ctl.issue = 1'b1;
                mul_a         = OPW'(r_env_m);
                mul_b         = OPW'(cfg_decay);
            end
            S_BASE: begin
                mul_ctl.issue = 1'b1;
                mul_a         = OPW'(r_diff);
                mul_b         = OPW'(K_BASE);
            end
            S_BDEC: begin
                mul_ctl.issue = 1'b1;
                mul_a         = OPW'(r_beat);
                mul_b         = OPW'(K_BDECAY);
            end
            S_PDEC: begin
                mul_ctl.issue = 1'b1;
                mul_a         = OPW'(r_pulse);
                mul_b         = OPW'(cfg_decay);
            end
            S_TMUL: begin
                mul_ctl.issue = 1'b1;
                mul_ctl.mode  = MOP_BEAT;
                mul_a         = OPW'(r_trans);
                mul_b         = cfg_beat_gain13;
            end
            S_RECIP: begin
                mul_ctl.issue = 1'b1;
                mul_ctl.mode  = MOP_RECIP;
                mul_a         = r_qc;
                mul_b         = K_RECIP;
            end
            default: ;
        endcase
    end

    // Datapath helpers: pulse clamp, input saturation, beat candidate, result
    always_comb begin
        if (i_pulse_strength < PULSE_MIN) begin
            n_psc = PULSE_MIN;
        end else if (i_pulse_strength > LVL_MAX) begin
            n_psc = LVL_MAX;
        end else begin
            n_psc = i_pulse_strength;
        end

        n_res_lvl = mul_res[LW-1:0];
        n_scaled  = (mul_res > RW'(LVL_MAX)) ? LVL_MAX : mul_res[LW-1:0];

        n_cand     = (mul_res > RW'(r_beat)) ? mul_res : RW'(r_beat);
        n_beat_fin = (n_cand > RW'(BEAT_SAT)) ? BEAT_SAT : n_cand[BW-1:0];

        n_dl     = cfg_enabled ? r_env_d : '0;
        n_ml     = cfg_enabled ? r_env_m : '0;
        n_beat_o = (r_beat > BW'(LVL_MAX)) ? LVL_MAX : r_beat[LW-1:0];
        n_master = (n_dl > n_ml) ? n_dl : n_ml;
        if (r_pulse > n_master) begin
            n_master = r_pulse;
        end
    end

    // Level state and output handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_env_d     <= '0;
            r_env_m     <= '0;
            r_base      <= '0;
            r_beat      <= '0;
            r_pulse     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Raise valid as a result is loaded, drop it once transferred
            if ((r_state == S_OUT) && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid && (i_pulse_strength != '0) && (n_psc > r_pulse)) begin
                        r_pulse <= n_psc;
                    end
                end
                S_BASE:  r_env_d <= (r_din > n_res_lvl) ? r_din : n_res_lvl;
                S_BDEC:  r_env_m <= (r_min > n_res_lvl) ? r_min : n_res_lvl;
                S_PDEC:  r_base  <= r_up ? (r_base + n_res_lvl) : (r_base - n_res_lvl);
                S_TRANS: r_beat  <= mul_res[BW-1:0];
                S_TMUL:  r_pulse <= n_res_lvl;
                S_CAND: begin
                    if (cfg_enabled) begin
                        r_beat <= n_beat_fin;
                    end else begin
                        r_base  <= '0;
                        r_beat  <= '0;
                        r_pulse <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Per-tick working values and output payload
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    r_raw_d <= i_desktop_raw;
                    r_raw_m <= i_microphone_raw;
                end
            end
            S_ENVD: r_din <= n_scaled;
            S_ENVM: begin
                r_min  <= n_scaled;
                r_up   <= (r_din >= r_base);
                r_diff <= (r_din >= r_base) ? (r_din - r_base) : (r_base - r_din);
            end
            S_TRANS: r_trans <= (r_din > r_base) ? (r_din - r_base) : '0;
            S_QCLAMP: r_qc   <= (mul_res > Q_CLAMP) ? Q_CLAMP[OPW-1:0] : mul_res[OPW-1:0];
            S_OUT: begin
                if (slot_free) begin
                    r_out_master <= n_master;
                    r_out_dl     <= n_dl;
                    r_out_ml     <= n_ml;
                    r_out_beat   <= n_beat_o;
                    r_out_pl     <= r_pulse;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid        = r_out_valid;
    assign o_master_level     = r_out_master;
    assign o_desktop_level    = r_out_dl;
    assign o_microphone_level = r_out_ml;
    assign o_beat_out         = r_out_beat;
    assign o_pulse_level      = r_out_pl;

endmodule
